// ===== design/dc_exciter_voltage_regulator_assert.svh =====
// assertion macros for the dc exciter voltage regulator
// expects clk_i and rst_ni in the scope of use; no other dependencies
`ifndef DC_EXCITER_VOLTAGE_REGULATOR_ASSERT_SVH
`define DC_EXCITER_VOLTAGE_REGULATOR_ASSERT_SVH

// same-cycle implication
`define DCEVR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dcevr: same-cycle check failed");

// next-cycle implication
`define DCEVR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dcevr: next-cycle check failed");

`endif

// ===== design/dcevr_pkg.sv =====
// shared types, constants and microcode for the dc exciter voltage regulator
// no dependencies
package dcevr_pkg;

  localparam int DataW    = 32;
  localparam int FracBits = 20;
  localparam int CfgIdxW  = 8;
  localparam int RateW    = 21;
  localparam int GainW    = 31;

  localparam int SqrtIters = 32;
  localparam int SqrtSteps = (SqrtIters < 32) ? SqrtIters : 32;
  localparam int SqrtCntW  = $clog2(SqrtSteps + 1);
  localparam int DivBits   = DataW + FracBits;
  localparam int DivCntW   = $clog2(DivBits + 1);

  localparam longint OneL   = longint'(1) << FracBits;
  localparam longint C123L  = (OneL + 23 / 2) / 23;
  localparam longint C33L   = (33 * OneL + 310 / 2) / 310;
  localparam longint KneeL  = (23 * OneL + 10 / 2) / 10;
  localparam longint LoL    = -((9 * OneL + 10 / 2) / 10);

  localparam logic signed [DataW-1:0] QOne  = DataW'(OneL);
  localparam logic signed [DataW-1:0] QC123 = DataW'(C123L);
  localparam logic signed [DataW-1:0] QC33  = DataW'(C33L);
  localparam logic signed [DataW-1:0] QKnee = DataW'(KneeL);
  localparam logic signed [DataW-1:0] QLo   = DataW'(LoL);
  localparam logic signed [DataW-1:0] QMax  = DataW'(64'sd2147483647);
  localparam logic signed [DataW-1:0] QMin  = DataW'(-64'sd2147483648);
  // start state with reset gains: sat = 1/23, amp = 1/23 + 1.0, offset = amp / 1.0
  localparam logic signed [DataW-1:0] QRstAmp = DataW'(C123L + OneL);

  localparam logic [CfgIdxW-1:0] REG_RATE_T = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_RATE_F = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_RATE_A = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_RATE_E = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] REG_KA     = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] REG_KE     = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] REG_KF     = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] REG_SCALE  = CfgIdxW'(7);

  typedef enum logic [3:0] {
    OP_MUL, OP_RND, OP_ADD, OP_SUB, OP_SQ1, OP_SQ2, OP_DIV, OP_CLAMP, OP_KNEE, OP_END
  } op_e;

  typedef enum logic [4:0] {
    SRC_FILT, SRC_STAB, SRC_AMP, SRC_FIELD, SRC_SAT, SRC_OFF, SRC_T0, SRC_T1,
    SRC_VH, SRC_VD, SRC_VQ, SRC_VREF, SRC_RT, SRC_RF, SRC_RA, SRC_RE,
    SRC_KA, SRC_KE, SRC_KF, SRC_SCALE, SRC_C123, SRC_C33, SRC_ONE, SRC_ZERO
  } src_e;

  typedef enum logic [3:0] {
    DST_FILT, DST_STAB, DST_AMP, DST_FIELD, DST_SAT, DST_OFF, DST_T0, DST_T1,
    DST_VH, DST_OUT, DST_NONE
  } dst_e;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAIT} state_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    dst_e dst;
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic exec;
    logic load;
    logic busy;
  } ctl_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } sts_t;

  localparam int PcW = 6;
  localparam logic [PcW-1:0] PcAdvance = PcW'(0);
  localparam logic [PcW-1:0] PcInit    = PcW'(43);

  function automatic cmd_t mk(op_e o, src_e a, src_e b, dst_e d);
    cmd_t c;
    c.op  = o;
    c.a   = a;
    c.b   = b;
    c.dst = d;
    return c;
  endfunction

  function automatic cmd_t ucode(logic [PcW-1:0] pc);
    cmd_t c;
    case (pc)
      // magnitude of the terminal voltage
      6'd0:  c = mk(OP_MUL, SRC_VD, SRC_VD, DST_NONE);
      6'd1:  c = mk(OP_SQ1, SRC_ZERO, SRC_ZERO, DST_NONE);
      6'd2:  c = mk(OP_MUL, SRC_VQ, SRC_VQ, DST_NONE);
      6'd3:  c = mk(OP_SQ2, SRC_ZERO, SRC_ZERO, DST_VH);
      // transducer filter
      6'd4:  c = mk(OP_SUB, SRC_VH, SRC_FILT, DST_T0);
      6'd5:  c = mk(OP_MUL, SRC_RT, SRC_T0, DST_NONE);
      6'd6:  c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_T0);
      6'd7:  c = mk(OP_ADD, SRC_FILT, SRC_T0, DST_FILT);
      // stabilising feedback
      6'd8:  c = mk(OP_SUB, SRC_AMP, SRC_SAT, DST_T0);
      6'd9:  c = mk(OP_MUL, SRC_FIELD, SRC_KE, DST_NONE);
      6'd10: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_T1);
      6'd11: c = mk(OP_SUB, SRC_T0, SRC_T1, DST_T0);
      6'd12: c = mk(OP_MUL, SRC_KF, SRC_T0, DST_NONE);
      6'd13: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_T0);
      6'd14: c = mk(OP_SUB, SRC_T0, SRC_STAB, DST_T0);
      6'd15: c = mk(OP_MUL, SRC_RF, SRC_T0, DST_NONE);
      6'd16: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_T0);
      6'd17: c = mk(OP_ADD, SRC_STAB, SRC_T0, DST_STAB);
      // amplifier
      6'd18: c = mk(OP_SUB, SRC_VREF, SRC_FILT, DST_T0);
      6'd19: c = mk(OP_SUB, SRC_T0, SRC_STAB, DST_T0);
      6'd20: c = mk(OP_ADD, SRC_T0, SRC_OFF, DST_T0);
      6'd21: c = mk(OP_MUL, SRC_KA, SRC_T0, DST_NONE);
      6'd22: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_T0);
      6'd23: c = mk(OP_SUB, SRC_T0, SRC_AMP, DST_T0);
      6'd24: c = mk(OP_MUL, SRC_RA, SRC_T0, DST_NONE);
      6'd25: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_T0);
      6'd26: c = mk(OP_ADD, SRC_AMP, SRC_T0, DST_AMP);
      6'd27: c = mk(OP_CLAMP, SRC_AMP, SRC_ZERO, DST_AMP);
      // saturation
      6'd28: c = mk(OP_KNEE, SRC_FIELD, SRC_ZERO, DST_T1);
      6'd29: c = mk(OP_MUL, SRC_T1, SRC_FIELD, DST_NONE);
      6'd30: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_SAT);
      6'd31: c = mk(OP_MUL, SRC_SAT, SRC_FIELD, DST_NONE);
      6'd32: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_SAT);
      // field voltage
      6'd33: c = mk(OP_SUB, SRC_AMP, SRC_SAT, DST_T0);
      6'd34: c = mk(OP_MUL, SRC_KE, SRC_FIELD, DST_NONE);
      6'd35: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_T1);
      6'd36: c = mk(OP_SUB, SRC_T0, SRC_T1, DST_T0);
      6'd37: c = mk(OP_MUL, SRC_RE, SRC_T0, DST_NONE);
      6'd38: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_T0);
      6'd39: c = mk(OP_ADD, SRC_FIELD, SRC_T0, DST_FIELD);
      6'd40: c = mk(OP_MUL, SRC_SCALE, SRC_FIELD, DST_NONE);
      6'd41: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_OUT);
      6'd42: c = mk(OP_END, SRC_ZERO, SRC_ZERO, DST_NONE);
      // reload of the start state
      6'd43: c = mk(OP_ADD, SRC_ONE, SRC_ZERO, DST_FIELD);
      6'd44: c = mk(OP_MUL, SRC_C123, SRC_FIELD, DST_NONE);
      6'd45: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_SAT);
      6'd46: c = mk(OP_MUL, SRC_KE, SRC_FIELD, DST_NONE);
      6'd47: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_T0);
      6'd48: c = mk(OP_ADD, SRC_SAT, SRC_T0, DST_AMP);
      6'd49: c = mk(OP_DIV, SRC_AMP, SRC_KA, DST_OFF);
      6'd50: c = mk(OP_ADD, SRC_ONE, SRC_ZERO, DST_FILT);
      6'd51: c = mk(OP_ADD, SRC_ZERO, SRC_ZERO, DST_STAB);
      6'd52: c = mk(OP_MUL, SRC_SCALE, SRC_FIELD, DST_NONE);
      6'd53: c = mk(OP_RND, SRC_ZERO, SRC_ZERO, DST_OUT);
      default: c = mk(OP_END, SRC_ZERO, SRC_ZERO, DST_NONE);
    endcase
    return c;
  endfunction

endpackage

// ===== design/dcevr_cfg_if.sv =====
// register write channel of the dc exciter voltage regulator
// depends on dcevr_pkg
interface dcevr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dcevr_pkg::CfgIdxW-1:0] index;
  logic [dcevr_pkg::DataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/dcevr_in_if.sv =====
// input word channel of the dc exciter voltage regulator
// depends on dcevr_pkg
interface dcevr_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic signed [dcevr_pkg::DataW-1:0] volt_d;
  logic signed [dcevr_pkg::DataW-1:0] volt_q;
  logic signed [dcevr_pkg::DataW-1:0] volt_ref;

  modport source (output valid, req_type, volt_d, volt_q, volt_ref, input ready);
  modport sink   (input valid, req_type, volt_d, volt_q, volt_ref, output ready);
endinterface

// ===== design/dcevr_out_if.sv =====
// result word channel of the dc exciter voltage regulator
// depends on dcevr_pkg
interface dcevr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dcevr_pkg::DataW-1:0] field_drive;
  logic                              amp_clamped;

  modport source (output valid, field_drive, amp_clamped, input ready);
  modport sink   (input valid, field_drive, amp_clamped, output ready);
endinterface

// ===== design/dc_exciter_voltage_regulator.sv =====
// top level of the dc exciter voltage regulator: sequencer plus datapath
// depends on dcevr_pkg, the channel interfaces and the assertion header
// An advance word runs 42 microcode steps, one a cycle while none is held,
// on one shared 32x32 multiplier (two steps per product), and the square
// root step holds while it produces its 32 root bits one a cycle, then
// writes back. An initialise word holds its start-state division step while
// the divider produces its 52 quotient bits one a cycle. One word is worked
// on at a time; the next is taken once the sequencer is back in idle after
// the result is written, while a finished result may still sit in the
// output register. A result that has not been taken stalls the final step
// of the next word until it goes. Register writes are always taken.
`include "dc_exciter_voltage_regulator_assert.svh"

module dc_exciter_voltage_regulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  dcevr_cfg_if.sink   cfg_i,
  dcevr_in_if.sink    in_i,
  dcevr_out_if.source out_o
);

  dcevr_pkg::ctl_t ctl;
  dcevr_pkg::sts_t sts;
  logic            in_ready;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  dcevr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_req_type_i (in_i.req_type),
    .in_ready_o    (in_ready),
    .sts_i         (sts),
    .ctl_o         (ctl)
  );

  dcevr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cfg_we_i      (cfg_i.valid),
    .cfg_idx_i     (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .volt_d_i      (in_i.volt_d),
    .volt_q_i      (in_i.volt_q),
    .volt_ref_i    (in_i.volt_ref),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .field_drive_o (out_o.field_drive),
    .amp_clamped_o (out_o.amp_clamped)
  );

  `DCEVR_ASSERT_NXT(a_accept_starts_work, in_i.valid && in_i.ready, ctl.busy)
  `DCEVR_ASSERT_IMP(a_done_only_when_busy, sts.done, ctl.busy)
  `DCEVR_ASSERT_IMP(a_no_result_overwrite,
    out_o.valid && !out_o.ready && ctl.exec && ctl.cmd.op == dcevr_pkg::OP_RND,
    ctl.cmd.dst != dcevr_pkg::DST_OUT)

endmodule

// ===== design/dcevr_ctrl.sv =====
// sequencer: steps through the microcode held in dcevr_pkg
// depends on dcevr_pkg
module dcevr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_req_type_i,
  output logic              in_ready_o,
  input  dcevr_pkg::sts_t   sts_i,
  output dcevr_pkg::ctl_t   ctl_o
);

  dcevr_pkg::state_e               state_q, state_d;
  logic [dcevr_pkg::PcW-1:0]       pc_q, pc_d;
  dcevr_pkg::cmd_t                 cmd;
  logic                            accept;

  assign in_ready_o = (state_q == dcevr_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcevr_pkg::ST_IDLE;
      pc_q    <= dcevr_pkg::PcAdvance;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  always_comb begin
    cmd            = dcevr_pkg::ucode(pc_q);
    state_d        = state_q;
    pc_d           = pc_q;
    ctl_o.cmd      = cmd;
    ctl_o.exec     = 1'b0;
    ctl_o.load     = accept;
    ctl_o.busy     = (state_q != dcevr_pkg::ST_IDLE);
    unique case (state_q)
      dcevr_pkg::ST_IDLE: begin
        if (accept) begin
          pc_d    = in_req_type_i ? dcevr_pkg::PcInit : dcevr_pkg::PcAdvance;
          state_d = dcevr_pkg::ST_EXEC;
        end
      end
      dcevr_pkg::ST_EXEC: begin
        priority if (cmd.op == dcevr_pkg::OP_END) begin
          state_d = dcevr_pkg::ST_IDLE;
        end else if (cmd.op == dcevr_pkg::OP_SQ2 || cmd.op == dcevr_pkg::OP_DIV) begin
          ctl_o.exec = 1'b1;
          state_d    = dcevr_pkg::ST_WAIT;
        end else if (cmd.op == dcevr_pkg::OP_RND && cmd.dst == dcevr_pkg::DST_OUT &&
                     !sts_i.out_free) begin
          // previous result still waiting to be taken
          ctl_o.exec = 1'b0;
        end else begin
          ctl_o.exec = 1'b1;
          pc_d       = pc_q + 1'b1;
        end
      end
      dcevr_pkg::ST_WAIT: begin
        if (sts_i.done) begin
          pc_d    = pc_q + 1'b1;
          state_d = dcevr_pkg::ST_EXEC;
        end
      end
      default: state_d = dcevr_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== design/dcevr_datapath.sv =====
// datapath: state and register bank, shared multiplier with rounding,
// bit-serial square root and divider, output register; depends on dcevr_pkg
module dcevr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dcevr_pkg::ctl_t                     ctl_i,
  output dcevr_pkg::sts_t                     sts_o,
  input  logic                                cfg_we_i,
  input  logic [dcevr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [dcevr_pkg::DataW-1:0]         cfg_data_i,
  input  logic signed [dcevr_pkg::DataW-1:0]  volt_d_i,
  input  logic signed [dcevr_pkg::DataW-1:0]  volt_q_i,
  input  logic signed [dcevr_pkg::DataW-1:0]  volt_ref_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [dcevr_pkg::DataW-1:0]  field_drive_o,
  output logic                                amp_clamped_o
);

  localparam int W  = dcevr_pkg::DataW;
  localparam int FB = dcevr_pkg::FracBits;
  localparam int DB = dcevr_pkg::DivBits;
  localparam logic signed [2*W-1:0] RndHalf = (2*W)'(64'sd1 <<< (FB - 1));

  // configuration
  logic [dcevr_pkg::RateW-1:0] rate_t_q, rate_f_q, rate_a_q, rate_e_q;
  logic [dcevr_pkg::GainW-1:0] ka_q, kf_q, scale_q;
  logic signed [W-1:0]         ke_q;

  // model state and scratch
  logic signed [W-1:0] filt_q, stab_q, amp_q, field_q, sat_q, off_q;
  logic signed [W-1:0] t0_q, t1_q, vh_q, vd_q, vq_q, vref_q;
  logic                clamp_q;

  logic signed [W-1:0]   opa, opb;
  logic signed [2*W-1:0] prod_q, rnd_sum, rnd_sh;
  logic signed [W-1:0]   rnd_res, add_res, sub_res;
  logic signed [W:0]     add_ext, sub_ext;

  // square root
  logic [2*W-1:0]                    acc_q, sqn_q;
  logic [W+2:0]                      rem_q, remx, trial;
  logic [W-1:0]                      root_q, root_full;
  logic [dcevr_pkg::SqrtCntW-1:0]    sqcnt_q;
  logic                              sq_busy_q, sq_done;
  logic signed [W-1:0]               sq_res;

  // divider
  logic [DB-1:0]                     dq_q;
  logic [dcevr_pkg::GainW-1:0]       dden_q, drem_q;
  logic [dcevr_pkg::GainW:0]         drem2;
  logic [dcevr_pkg::DivCntW-1:0]     dcnt_q;
  logic                              dv_busy_q, dv_done, dneg_q, dnz_q;
  logic                              dgo;
  logic [W-1:0]                      dmag;
  logic signed [W-1:0]               dv_res;

  // output
  logic                out_valid_q;
  logic signed [W-1:0] drive_q;
  logic                clamped_out_q;

  logic                wr_en;
  logic signed [W-1:0] wr_data;
  logic                clamp_set;

  function automatic logic signed [W-1:0] pick(dcevr_pkg::src_e s);
    logic signed [W-1:0] v;
    unique case (s)
      dcevr_pkg::SRC_FILT:  v = filt_q;
      dcevr_pkg::SRC_STAB:  v = stab_q;
      dcevr_pkg::SRC_AMP:   v = amp_q;
      dcevr_pkg::SRC_FIELD: v = field_q;
      dcevr_pkg::SRC_SAT:   v = sat_q;
      dcevr_pkg::SRC_OFF:   v = off_q;
      dcevr_pkg::SRC_T0:    v = t0_q;
      dcevr_pkg::SRC_T1:    v = t1_q;
      dcevr_pkg::SRC_VH:    v = vh_q;
      dcevr_pkg::SRC_VD:    v = vd_q;
      dcevr_pkg::SRC_VQ:    v = vq_q;
      dcevr_pkg::SRC_VREF:  v = vref_q;
      dcevr_pkg::SRC_RT:    v = $signed(W'(rate_t_q));
      dcevr_pkg::SRC_RF:    v = $signed(W'(rate_f_q));
      dcevr_pkg::SRC_RA:    v = $signed(W'(rate_a_q));
      dcevr_pkg::SRC_RE:    v = $signed(W'(rate_e_q));
      dcevr_pkg::SRC_KA:    v = $signed(W'(ka_q));
      dcevr_pkg::SRC_KE:    v = ke_q;
      dcevr_pkg::SRC_KF:    v = $signed(W'(kf_q));
      dcevr_pkg::SRC_SCALE: v = $signed(W'(scale_q));
      dcevr_pkg::SRC_C123:  v = dcevr_pkg::QC123;
      dcevr_pkg::SRC_C33:   v = dcevr_pkg::QC33;
      dcevr_pkg::SRC_ONE:   v = dcevr_pkg::QOne;
      dcevr_pkg::SRC_ZERO:  v = '0;
      default:              v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(ctl_i.cmd.a);
    opb = pick(ctl_i.cmd.b);
  end

  // rounding half up, then saturation
  always_comb begin
    rnd_sum = prod_q + RndHalf;
    rnd_sh  = rnd_sum >>> FB;
    priority if (rnd_sh > (2*W)'(dcevr_pkg::QMax)) rnd_res = dcevr_pkg::QMax;
    else if (rnd_sh < (2*W)'(dcevr_pkg::QMin))     rnd_res = dcevr_pkg::QMin;
    else                                           rnd_res = rnd_sh[W-1:0];
  end

  always_comb begin
    add_ext = (W+1)'(opa) + (W+1)'(opb);
    sub_ext = (W+1)'(opa) - (W+1)'(opb);
    if (add_ext[W] != add_ext[W-1]) add_res = add_ext[W] ? dcevr_pkg::QMin : dcevr_pkg::QMax;
    else                            add_res = add_ext[W-1:0];
    if (sub_ext[W] != sub_ext[W-1]) sub_res = sub_ext[W] ? dcevr_pkg::QMin : dcevr_pkg::QMax;
    else                            sub_res = sub_ext[W-1:0];
  end

  // square root step: one result bit per cycle
  always_comb begin
    remx      = {rem_q[W:0], sqn_q[2*W-1 -: 2]};
    trial     = {1'b0, root_q, 2'b01};
    sq_done   = sq_busy_q && (sqcnt_q == '0);
    root_full = root_q << (W - dcevr_pkg::SqrtSteps);
    sq_res    = root_full[W-1] ? dcevr_pkg::QMax : $signed(root_full);
  end

  // divider step: restoring, one quotient bit per cycle
  always_comb begin
    dgo     = ctl_i.exec && (ctl_i.cmd.op == dcevr_pkg::OP_DIV);
    dmag    = opa[W-1] ? W'(-opa) : W'(opa);
    drem2   = {drem_q, dq_q[DB-1]};
    dv_done = dv_busy_q && (dcnt_q == '0);
    priority if (dden_q == '0) begin
      dv_res = !dnz_q ? '0 : (dneg_q ? dcevr_pkg::QMin : dcevr_pkg::QMax);
    end else if (!dneg_q) begin
      dv_res = (dq_q > DB'(dcevr_pkg::QMax)) ? dcevr_pkg::QMax : $signed(dq_q[W-1:0]);
    end else begin
      dv_res = (dq_q >= (DB'(1) << (W - 1))) ? dcevr_pkg::QMin : $signed(W'(-dq_q[W-1:0]));
    end
  end

  // write-back selection
  always_comb begin
    wr_en     = 1'b0;
    wr_data   = '0;
    clamp_set = 1'b0;
    if (sq_done) begin
      wr_en   = 1'b1;
      wr_data = sq_res;
    end else if (dv_done) begin
      wr_en   = 1'b1;
      wr_data = dv_res;
    end else if (ctl_i.exec) begin
      unique case (ctl_i.cmd.op)
        dcevr_pkg::OP_RND: begin
          wr_en   = 1'b1;
          wr_data = rnd_res;
        end
        dcevr_pkg::OP_ADD: begin
          wr_en   = 1'b1;
          wr_data = add_res;
        end
        dcevr_pkg::OP_SUB: begin
          wr_en   = 1'b1;
          wr_data = sub_res;
        end
        dcevr_pkg::OP_KNEE: begin
          wr_en   = 1'b1;
          wr_data = (opa <= dcevr_pkg::QKnee) ? dcevr_pkg::QC123 : dcevr_pkg::QC33;
        end
        dcevr_pkg::OP_CLAMP: begin
          wr_en = 1'b1;
          priority if (opa > dcevr_pkg::QOne) begin
            wr_data   = dcevr_pkg::QOne;
            clamp_set = 1'b1;
          end else if (opa < dcevr_pkg::QLo) begin
            wr_data   = dcevr_pkg::QLo;
            clamp_set = 1'b1;
          end else begin
            wr_data = opa;
          end
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // registers with reset: configuration, model state, control of the units
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_t_q    <= '0;
      rate_f_q    <= '0;
      rate_a_q    <= '0;
      rate_e_q    <= '0;
      ka_q        <= dcevr_pkg::GainW'(dcevr_pkg::QOne);
      ke_q        <= dcevr_pkg::QOne;
      kf_q        <= '0;
      scale_q     <= dcevr_pkg::GainW'(dcevr_pkg::QOne);
      filt_q      <= dcevr_pkg::QOne;
      stab_q      <= '0;
      amp_q       <= dcevr_pkg::QRstAmp;
      field_q     <= dcevr_pkg::QOne;
      sat_q       <= dcevr_pkg::QC123;
      off_q       <= dcevr_pkg::QRstAmp;
      clamp_q     <= 1'b0;
      sq_busy_q   <= 1'b0;
      sqcnt_q     <= '0;
      dv_busy_q   <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dcevr_pkg::REG_RATE_T: rate_t_q <= cfg_data_i[dcevr_pkg::RateW-1:0];
          dcevr_pkg::REG_RATE_F: rate_f_q <= cfg_data_i[dcevr_pkg::RateW-1:0];
          dcevr_pkg::REG_RATE_A: rate_a_q <= cfg_data_i[dcevr_pkg::RateW-1:0];
          dcevr_pkg::REG_RATE_E: rate_e_q <= cfg_data_i[dcevr_pkg::RateW-1:0];
          dcevr_pkg::REG_KA:     ka_q     <= cfg_data_i[dcevr_pkg::GainW-1:0];
          dcevr_pkg::REG_KE:     ke_q     <= $signed(cfg_data_i);
          dcevr_pkg::REG_KF:     kf_q     <= cfg_data_i[dcevr_pkg::GainW-1:0];
          dcevr_pkg::REG_SCALE:  scale_q  <= cfg_data_i[dcevr_pkg::GainW-1:0];
          default: ;
        endcase
      end

      if (ctl_i.load)     clamp_q <= 1'b0;
      else if (clamp_set) clamp_q <= 1'b1;

      if (wr_en) begin
        unique case (ctl_i.cmd.dst)
          dcevr_pkg::DST_FILT:  filt_q  <= wr_data;
          dcevr_pkg::DST_STAB:  stab_q  <= wr_data;
          dcevr_pkg::DST_AMP:   amp_q   <= wr_data;
          dcevr_pkg::DST_FIELD: field_q <= wr_data;
          dcevr_pkg::DST_SAT:   sat_q   <= wr_data;
          dcevr_pkg::DST_OFF:   off_q   <= wr_data;
          default: ;
        endcase
      end

      if (ctl_i.exec && ctl_i.cmd.op == dcevr_pkg::OP_SQ2) begin
        sq_busy_q <= 1'b1;
        sqcnt_q   <= dcevr_pkg::SqrtCntW'(dcevr_pkg::SqrtSteps);
      end else if (sq_done) begin
        sq_busy_q <= 1'b0;
      end else if (sq_busy_q) begin
        sqcnt_q <= sqcnt_q - 1'b1;
      end

      if (dgo) begin
        dv_busy_q <= 1'b1;
        dcnt_q    <= dcevr_pkg::DivCntW'(DB);
      end else if (dv_done) begin
        dv_busy_q <= 1'b0;
      end else if (dv_busy_q) begin
        dcnt_q <= dcnt_q - 1'b1;
      end

      if (wr_en && ctl_i.cmd.dst == dcevr_pkg::DST_OUT) out_valid_q <= 1'b1;
      else if (out_ready_i)                             out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      vd_q   <= volt_d_i;
      vq_q   <= volt_q_i;
      vref_q <= volt_ref_i;
    end
    if (ctl_i.exec && ctl_i.cmd.op == dcevr_pkg::OP_MUL) prod_q <= opa * opb;
    if (ctl_i.exec && ctl_i.cmd.op == dcevr_pkg::OP_SQ1) acc_q  <= prod_q;
    if (wr_en) begin
      unique case (ctl_i.cmd.dst)
        dcevr_pkg::DST_T0: t0_q <= wr_data;
        dcevr_pkg::DST_T1: t1_q <= wr_data;
        dcevr_pkg::DST_VH: vh_q <= wr_data;
        dcevr_pkg::DST_OUT: begin
          drive_q       <= wr_data;
          clamped_out_q <= clamp_q;
        end
        default: ;
      endcase
    end

    if (ctl_i.exec && ctl_i.cmd.op == dcevr_pkg::OP_SQ2) begin
      sqn_q  <= acc_q + prod_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (sq_busy_q && !sq_done) begin
      sqn_q <= sqn_q << 2;
      if (remx >= trial) begin
        rem_q  <= remx - trial;
        root_q <= {root_q[W-2:0], 1'b1};
      end else begin
        rem_q  <= remx;
        root_q <= {root_q[W-2:0], 1'b0};
      end
    end

    if (dgo) begin
      dq_q   <= {dmag, FB'(0)};
      drem_q <= '0;
      dden_q <= opb[dcevr_pkg::GainW-1:0];
      dneg_q <= opa[W-1];
      dnz_q  <= (opa != '0);
    end else if (dv_busy_q && !dv_done) begin
      if (drem2 >= {1'b0, dden_q}) begin
        drem_q <= dcevr_pkg::GainW'(drem2 - {1'b0, dden_q});
        dq_q   <= {dq_q[DB-2:0], 1'b1};
      end else begin
        drem_q <= drem2[dcevr_pkg::GainW-1:0];
        dq_q   <= {dq_q[DB-2:0], 1'b0};
      end
    end
  end

  assign sts_o.done     = sq_done || dv_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign field_drive_o  = drive_q;
  assign amp_clamped_o  = clamped_out_q;

endmodule
